/* hdl/bsq_pkg.sv */
package bsq_pkg;

  localparam int CFG_W          = 10;
  localparam int SAMPLE_W       = 32;
  localparam int DITHER_W       = 20;
  localparam int CODE_W         = 8;
  localparam int MAX_BUCKET_DEF = 512;

  localparam logic [CFG_W-1:0] BUCKET_SIZE_RST = CFG_W'(512);

  localparam logic signed [63:0] Q_SCALE = 64'sd255000000;
  localparam logic [DITHER_W-1:0] D_SCALE = DITHER_W'(1000000);

  localparam int DIV_STEPS = 9;

  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_CODE  = 1'b1;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_QUANT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic add;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_quant;
    logic close;
  } dp_stat_t;

endpackage

/* hdl/bsq_if.sv */
interface bsq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [bsq_pkg::SAMPLE_W-1:0]  sample;
  logic        [bsq_pkg::DITHER_W-1:0]  dither;
  logic                                 last;

  modport source (output valid, cmd, sample, dither, last, input ready);
  modport sink   (input valid, cmd, sample, dither, last, output ready);
endinterface

interface bsq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic        [bsq_pkg::CODE_W-1:0]    code;
  logic signed [bsq_pkg::SAMPLE_W-1:0]  bucket_max;
  logic signed [bsq_pkg::SAMPLE_W-1:0]  bucket_min;

  modport source (output valid, kind, code, bucket_max, bucket_min, input ready);
  modport sink   (input valid, kind, code, bucket_max, bucket_min, output ready);
endinterface

/* hdl/bsq_ctrl.sv */
module bsq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bsq_pkg::dp_stat_t stat,
  output bsq_pkg::dp_cmd_t  cmd
);
  import bsq_pkg::*;

  localparam int DC_W = $clog2(DIV_STEPS);

  state_t          state, state_next;
  logic [DC_W-1:0] div_cnt, div_cnt_next;
  logic            ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
      ovalid  <= ovalid_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    ovalid_next  = ovalid & ~out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_quant) begin
          state_next = ST_MUL;
        end else if (stat.close) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add      = 1'b1;
        div_cnt_next = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + DC_W'(1);
        if (div_cnt == DC_W'(DIV_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid || out_ready) begin
          cmd.emit    = 1'b1;
          ovalid_next = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = ovalid;

endmodule

/* hdl/bsq_dp.sv */
module bsq_dp #(
  parameter int MAX_BUCKET = bsq_pkg::MAX_BUCKET_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic        [bsq_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                                in_cmd,
  input  logic signed [bsq_pkg::SAMPLE_W-1:0] in_sample,
  input  logic        [bsq_pkg::DITHER_W-1:0] in_dither,
  input  logic                                in_last,
  input  bsq_pkg::dp_cmd_t                    cmd,
  output bsq_pkg::dp_stat_t                   stat,
  output logic                                out_kind,
  output logic        [bsq_pkg::CODE_W-1:0]   out_code,
  output logic signed [bsq_pkg::SAMPLE_W-1:0] out_max,
  output logic signed [bsq_pkg::SAMPLE_W-1:0] out_min
);
  import bsq_pkg::*;

  localparam int CNT_W = $clog2(MAX_BUCKET + 1);
  localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DEN_W = SAMPLE_W + DITHER_W;
  localparam int DSH_W = DEN_W + DIV_STEPS - 1;

  logic [CFG_W-1:0]           bucket_size;
  logic                       cmd_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [DITHER_W-1:0]        dither_q;
  logic                       last_q;

  logic signed [SAMPLE_W-1:0] running_max, running_min;
  logic signed [SAMPLE_W-1:0] latched_max, latched_min;
  logic [CNT_W-1:0]           scan_count;

  logic signed [SAMPLE_W:0]   diff_q, rng_q;
  logic                       empty_q;
  logic signed [63:0]         p1_q;
  logic [DEN_W-1:0]           p2_q, den_q;
  logic signed [63:0]         rem;
  logic                       neg_q;
  logic [DSH_W-1:0]           dsh;
  logic [DIV_STEPS-1:0]       quo;

  logic [EW-1:0]              cfg_ext, max_ext, eff, cnt_ext;
  logic [CNT_W-1:0]           count_next;
  logic signed [SAMPLE_W-1:0] new_max, new_min;
  logic signed [SAMPLE_W:0]   diff, rng;
  logic                       take;

  always_comb begin
    cfg_ext = EW'(bucket_size);
    max_ext = EW'(MAX_BUCKET);
    if (bucket_size == '0) begin
      eff = EW'(1);
    end else if (cfg_ext > max_ext) begin
      eff = max_ext;
    end else begin
      eff = cfg_ext;
    end
    count_next = scan_count + CNT_W'(1);
    cnt_ext    = EW'(count_next);
    if (scan_count == '0) begin
      new_max = sample_q;
      new_min = sample_q;
    end else begin
      new_max = (sample_q > running_max) ? sample_q : running_max;
      new_min = (sample_q < running_min) ? sample_q : running_min;
    end
    diff = (SAMPLE_W+1)'(sample_q) - (SAMPLE_W+1)'(latched_min);
    rng  = (SAMPLE_W+1)'(latched_max) - (SAMPLE_W+1)'(latched_min);
    take = ($unsigned(rem) >= 64'(dsh));
  end

  assign stat.is_quant = (cmd_q == CMD_QUANT);
  assign stat.close    = (cnt_ext >= eff) || last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= BUCKET_SIZE_RST;
      running_max <= '0;
      running_min <= '0;
      latched_max <= '0;
      latched_min <= '0;
      scan_count  <= '0;
    end else begin
      if (cfg_we) begin
        bucket_size <= cfg_wdata;
      end
      if (cmd.exec && cmd_q == CMD_SCAN) begin
        running_max <= new_max;
        running_min <= new_min;
        if (stat.close) begin
          latched_max <= new_max;
          latched_min <= new_min;
          scan_count  <= '0;
        end else begin
          scan_count  <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q    <= in_cmd;
      sample_q <= in_sample;
      dither_q <= in_dither;
      last_q   <= in_last;
    end
    if (cmd.exec) begin
      diff_q  <= diff;
      rng_q   <= rng;
      empty_q <= (rng <= 0);
    end
    if (cmd.mul) begin
      p1_q  <= 64'(diff_q) * Q_SCALE;
      p2_q  <= DEN_W'(dither_q) * DEN_W'(rng_q[SAMPLE_W-1:0]);
      den_q <= DEN_W'(rng_q[SAMPLE_W-1:0]) * DEN_W'(D_SCALE);
    end
    if (cmd.add) begin
      rem   <= p1_q + $signed(64'(p2_q));
      neg_q <= p1_q[63] && (64'(p2_q) < 64'(-p1_q));
      dsh   <= {den_q, {(DIV_STEPS-1){1'b0}}};
      quo   <= '0;
    end
    if (cmd.div_step) begin
      if (take) begin
        rem <= rem - $signed(64'(dsh));
      end
      quo <= {quo[DIV_STEPS-2:0], take};
      dsh <= dsh >> 1;
    end
    if (cmd.emit) begin
      out_kind <= cmd_q;
      if (cmd_q == CMD_QUANT) begin
        out_max <= '0;
        out_min <= '0;
        if (empty_q || neg_q) begin
          out_code <= '0;
        end else if (quo[DIV_STEPS-1]) begin
          out_code <= '1;
        end else begin
          out_code <= quo[CODE_W-1:0];
        end
      end else begin
        out_code <= '0;
        out_max  <= latched_max;
        out_min  <= latched_min;
      end
    end
  end

endmodule

/* hdl/bucketed_stochastic_quantizer.sv */
// Bucketed min/max quantizer with stochastic rounding, 8-bit codes.
// samples: valid/ready channel of words {cmd, sample, dither, last}.
//   cmd 0 scans a Q16.16 sample into the running bucket range; when the
//   bucket holds bucket_size samples, or last is set, a range word
//   (kind 0, bucket_max, bucket_min) is emitted and the range latched.
//   cmd 1 quantizes a sample against the latched range and emits a code
//   word (kind 1, code = floor((sample-min)*255/(max-min) + dither/1e6),
//   clamped to 0..255, 0 for an empty range).
// results: valid/ready channel of result words.
// cfg_we/cfg_wdata: writes bucket_size (0 acts as 1, capped at MAX_BUCKET);
//   write only while idle.
// One item at a time. A scan loads the word and updates the range, and
// when it closes a bucket also loads the output register. A quantize takes
// one load, one subtract, one multiply, one add, then 9 steps of a restoring
// divider (one quotient bit per cycle), and a load of the output register.
// The output register lets a new word be accepted while a result waits;
// a stalled receiver only blocks the next item that has a result to emit.
// Synchronous reset: bucket_size 512, range state and counters cleared.
module bucketed_stochastic_quantizer #(
  parameter int MAX_BUCKET = bsq_pkg::MAX_BUCKET_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bsq_pkg::CFG_W-1:0] cfg_wdata,
  bsq_in_if.sink                    samples,
  bsq_out_if.source                 results
);
  import bsq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bsq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bsq_dp #(
    .MAX_BUCKET (MAX_BUCKET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_cmd    (samples.cmd),
    .in_sample (samples.sample),
    .in_dither (samples.dither),
    .in_last   (samples.last),
    .cmd       (cmd),
    .stat      (stat),
    .out_kind  (results.kind),
    .out_code  (results.code),
    .out_max   (results.bucket_max),
    .out_min   (results.bucket_min)
  );

endmodule
